// ===== rtl/rmsw_pkg.sv =====
// Package with the shared types and constants of the running median window.
package rmsw_pkg;

    localparam int WINDOW_DEPTH = 17;
    localparam int MIDDLE_INDEX = 8;
    localparam int MID_SLOT = (MIDDLE_INDEX < WINDOW_DEPTH) ? MIDDLE_INDEX : WINDOW_DEPTH - 1;
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W = 8;

    localparam logic signed [15:0] INVALID_MOISTURE = -16'sd9999;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 8'd255;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [15:0] moist;
        logic signed [15:0] temp;
    } pair_t;

    typedef struct packed {
        logic  tok;
        pair_t pair;
    } link_t;

    typedef struct packed {
        logic inj_up;
        logic inj_dn;
    } cell_ctl_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] sample_moisture;
        logic signed [15:0] sample_temperature;
    } in_beat_t;

    typedef struct packed {
        logic               accepted;
        logic signed [15:0] median_moisture;
        logic signed [15:0] median_temperature;
        logic [COUNT_W-1:0] sample_count;
    } out_beat_t;

endpackage

// ===== rtl/rmsw_cell.sv =====
// One window slot: holds an entry, checks bracketing and passes carries to its neighbors.
module rmsw_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rmsw_pkg::cell_ctl_t       ctl,
    input  rmsw_pkg::pair_t           sample,
    input  logic signed [15:0]        lower_moist,
    input  logic signed [15:0]        upper_moist,
    input  rmsw_pkg::link_t           up_in,
    input  rmsw_pkg::link_t           dn_in,
    output rmsw_pkg::link_t           up_out,
    output rmsw_pkg::link_t           dn_out,
    output rmsw_pkg::pair_t           entry,
    output logic                      lo_hit,
    output logic                      hi_hit
);
    import rmsw_pkg::*;

    pair_t entry_reg;
    pair_t entry_next;
    link_t up_reg;
    link_t up_next;
    link_t dn_reg;
    link_t dn_next;
    pair_t up_carry;
    pair_t dn_carry;
    logic  up_active;
    logic  dn_active;
    logic  empty;

    always_comb
    begin
        empty = (entry_reg.moist == 16'sd0);
        up_active = ctl.inj_up | up_in.tok;
        dn_active = ctl.inj_dn | dn_in.tok;
        up_carry = ctl.inj_up ? sample : up_in.pair;
        dn_carry = ctl.inj_dn ? sample : dn_in.pair;

        entry_next = entry_reg;
        if (up_active)
        begin
            entry_next = up_carry;
        end
        else if (dn_active)
        begin
            entry_next = dn_carry;
        end

        up_next.tok = up_active;
        up_next.pair = empty ? up_carry : entry_reg;
        dn_next.tok = dn_active;
        dn_next.pair = empty ? dn_carry : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            up_reg <= '0;
            dn_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            up_reg <= up_next;
            dn_reg <= dn_next;
        end
    end

    assign up_out = up_reg;
    assign dn_out = dn_reg;
    assign entry = entry_reg;
    assign lo_hit = (sample.moist >= lower_moist) && (sample.moist <= entry_reg.moist);
    assign hi_hit = (sample.moist >= entry_reg.moist) && (sample.moist <= upper_moist);

endmodule

// ===== rtl/running_median_sorted_window_core.sv =====
// Top level of the running median window: sequencer, row of slot cells and result register.
// Each input beat yields one result beat reporting the middle entry of a 17-slot window
// of moisture and temperature pairs kept ordered by moisture. A clear beat, an invalid
// reading or a sample after the count has reached 255 goes straight from the decision to
// the result register. A sample below or above the middle entry first runs a bracket
// search (one slot a cycle from the middle outward), then a carry that walks from the
// insertion slot to that end of the row (one cell a cycle). A sample equal to the middle
// entry needs no search and walks both halves.
// A new beat is taken once the previous one has been placed in the result register.
module running_median_sorted_window_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rmsw_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rmsw_pkg::out_beat_t  out_data
);
    import rmsw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH_LO,
        ST_SEARCH_HI,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_FINISH
    } state_t;

    localparam logic [PTR_W-1:0] MID_PTR = PTR_W'(MID_SLOT);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);

    state_t             state_reg;
    in_beat_t           beat_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic               eq_reg;
    logic               took_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    out_beat_t          out_data_reg;

    pair_t              sample;
    pair_t              entry [WINDOW_DEPTH];
    link_t              up_link [WINDOW_DEPTH];
    link_t              dn_link [WINDOW_DEPTH];
    cell_ctl_t          ctl [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] lo_hit;
    logic [WINDOW_DEPTH-1:0] hi_hit;

    logic               inj_up;
    logic               inj_dn;
    logic [PTR_W-1:0]   inj_pos;
    logic               up_done;
    logic               dn_done;

    assign sample.moist = beat_reg.sample_moisture;
    assign sample.temp = beat_reg.sample_temperature;
    assign up_done = up_link[WINDOW_DEPTH-1].tok;
    assign dn_done = dn_link[0].tok;

    always_comb
    begin
        inj_up = 1'b0;
        inj_dn = 1'b0;
        inj_pos = ptr_reg;
        unique case (state_reg)
            ST_DECIDE:
            begin
                inj_pos = MID_PTR;
                inj_up = (beat_reg.action == ACTION_SAMPLE) && (count_reg != COUNT_FULL)
                         && (sample.moist != INVALID_MOISTURE)
                         && (sample.moist == entry[MID_SLOT].moist);
            end
            ST_SEARCH_LO:
            begin
                inj_up = (ptr_reg == '0) || lo_hit[ptr_reg];
            end
            ST_SEARCH_HI:
            begin
                inj_dn = (ptr_reg == LAST_PTR) || hi_hit[ptr_reg];
            end
            ST_SHIFT_UP:
            begin
                inj_pos = MID_PTR;
                inj_dn = up_done && eq_reg;
            end
            default:
            begin
                inj_up = 1'b0;
                inj_dn = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic signed [15:0] lower_moist;
        logic signed [15:0] upper_moist;
        link_t              up_feed;
        link_t              dn_feed;

        if (i == 0)
        begin : g_bottom
            assign lower_moist = '0;
            assign up_feed = '0;
        end
        else
        begin : g_inner_lo
            assign lower_moist = entry[i-1].moist;
            assign up_feed = up_link[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_top
            assign upper_moist = '0;
            assign dn_feed = '0;
        end
        else
        begin : g_inner_hi
            assign upper_moist = entry[i+1].moist;
            assign dn_feed = dn_link[i+1];
        end

        assign ctl[i].inj_up = inj_up && (inj_pos == PTR_W'(i));
        assign ctl[i].inj_dn = inj_dn && (inj_pos == PTR_W'(i));

        rmsw_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl[i]),
            .sample      (sample),
            .lower_moist (lower_moist),
            .upper_moist (upper_moist),
            .up_in       (up_feed),
            .dn_in       (dn_feed),
            .up_out      (up_link[i]),
            .dn_out      (dn_link[i]),
            .entry       (entry[i]),
            .lo_hit      (lo_hit[i]),
            .hi_hit      (hi_hit[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg <= '0;
            eq_reg <= 1'b0;
            took_reg <= 1'b0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    took_reg <= 1'b0;
                    ptr_reg <= MID_PTR;
                    eq_reg <= 1'b0;
                    if (beat_reg.action == ACTION_CLEAR)
                    begin
                        count_reg <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else if ((count_reg == COUNT_FULL) || (sample.moist == INVALID_MOISTURE))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        took_reg <= 1'b1;
                        if (sample.moist < entry[MID_SLOT].moist)
                        begin
                            state_reg <= ST_SEARCH_LO;
                        end
                        else if (sample.moist > entry[MID_SLOT].moist)
                        begin
                            state_reg <= ST_SEARCH_HI;
                        end
                        else
                        begin
                            eq_reg <= 1'b1;
                            state_reg <= ST_SHIFT_UP;
                        end
                    end
                end
                ST_SEARCH_LO:
                begin
                    if (inj_up)
                    begin
                        state_reg <= ST_SHIFT_UP;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg - 1'b1;
                    end
                end
                ST_SEARCH_HI:
                begin
                    if (inj_dn)
                    begin
                        state_reg <= ST_SHIFT_DN;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                ST_SHIFT_UP:
                begin
                    if (up_done)
                    begin
                        eq_reg <= 1'b0;
                        state_reg <= eq_reg ? ST_SHIFT_DN : ST_FINISH;
                    end
                end
                ST_SHIFT_DN:
                begin
                    if (dn_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            beat_reg <= in_data;
        end
        if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
        begin
            out_data_reg.accepted <= took_reg;
            out_data_reg.median_moisture <= entry[MID_SLOT].moist;
            out_data_reg.median_temperature <= entry[MID_SLOT].temp;
            out_data_reg.sample_count <= count_reg;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) !(inj_up && inj_dn))
        else $error("Upward and downward insertion requested together.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(up_done || dn_done))
        else $error("Carry still moving while a new beat may be taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH_LO || state_reg == ST_SEARCH_HI) |-> took_reg)
        else $error("Search running for a sample that was not taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.accepted) |-> (out_data.sample_count != '0))
        else $error("Inserted sample reported with a zero count.");
`endif

endmodule

// ===== tb/sv/median_window_checker.sv =====
// Checker that predicts every result beat of the running median window and compares it.
`timescale 1ns / 100ps
module median_window_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  rmsw_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rmsw_pkg::out_beat_t out_data,
    output int                  fail_count,
    output int                  medians_owed
);
    import rmsw_pkg::*;

    pair_t              shadow_win [WINDOW_DEPTH];
    logic [COUNT_W-1:0] shadow_count;
    out_beat_t          medians_due [$];
    out_beat_t          want;
    int                 errs;

    function automatic void carry_toward_top(input pair_t val, input int pos);
        pair_t carry;
        pair_t spill;
        carry = val;
        for (int i = pos; i < WINDOW_DEPTH; i++)
        begin
            spill = (shadow_win[i].moist == 16'sd0) ? carry : shadow_win[i];
            shadow_win[i] = carry;
            carry = spill;
        end
    endfunction

    function automatic void carry_toward_bottom(input pair_t val, input int pos);
        pair_t carry;
        pair_t spill;
        carry = val;
        for (int i = pos; i >= 0; i--)
        begin
            spill = (shadow_win[i].moist == 16'sd0) ? carry : shadow_win[i];
            shadow_win[i] = carry;
            carry = spill;
        end
    endfunction

    function automatic out_beat_t next_median(input in_beat_t beat);
        out_beat_t          res;
        pair_t              val;
        logic signed [15:0] m;
        int                 pos;
        logic               hit;
        res = '0;
        val.moist = beat.sample_moisture;
        val.temp = beat.sample_temperature;
        m = $signed(val.moist);
        hit = 1'b0;
        if (beat.action == ACTION_CLEAR)
        begin
            shadow_count = '0;
        end
        else if (shadow_count != COUNT_FULL && m != INVALID_MOISTURE)
        begin
            if (m < $signed(shadow_win[MID_SLOT].moist))
            begin
                pos = 0;
                for (int i = MID_SLOT; i > 0; i--)
                begin
                    if (!hit && m >= $signed(shadow_win[i-1].moist)
                             && m <= $signed(shadow_win[i].moist))
                    begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                carry_toward_top(val, pos);
            end
            else if (m > $signed(shadow_win[MID_SLOT].moist))
            begin
                pos = WINDOW_DEPTH - 1;
                for (int i = MID_SLOT; i < WINDOW_DEPTH - 1; i++)
                begin
                    if (!hit && m >= $signed(shadow_win[i].moist)
                             && m <= $signed(shadow_win[i+1].moist))
                    begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                carry_toward_bottom(val, pos);
            end
            else
            begin
                carry_toward_top(val, MID_SLOT);
                carry_toward_bottom(val, MID_SLOT);
            end
            shadow_count = shadow_count + 1'b1;
            res.accepted = 1'b1;
        end
        res.median_moisture = shadow_win[MID_SLOT].moist;
        res.median_temperature = shadow_win[MID_SLOT].temp;
        res.sample_count = shadow_count;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                shadow_win[i] = '0;
            end
            shadow_count = '0;
            medians_due.delete();
            errs = 0;
            fail_count <= 0;
            medians_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (medians_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected, got %h", $time, out_data);
                    errs++;
                end
                else
                begin
                    want = medians_due.pop_front();
                    if (out_data.accepted !== want.accepted)
                    begin
                        $display("%0t: accepted expected %0d, got %0d",
                                 $time, want.accepted, out_data.accepted);
                        errs++;
                    end
                    if (out_data.median_moisture !== want.median_moisture)
                    begin
                        $display("%0t: median_moisture expected %0d, got %0d",
                                 $time, want.median_moisture, out_data.median_moisture);
                        errs++;
                    end
                    if (out_data.median_temperature !== want.median_temperature)
                    begin
                        $display("%0t: median_temperature expected %0d, got %0d",
                                 $time, want.median_temperature, out_data.median_temperature);
                        errs++;
                    end
                    if (out_data.sample_count !== want.sample_count)
                    begin
                        $display("%0t: sample_count expected %0d, got %0d",
                                 $time, want.sample_count, out_data.sample_count);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                medians_due.push_back(next_median(in_data));
            end
            fail_count <= errs;
            medians_owed <= medians_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_running_median_sorted_window_core.sv =====
// Top of the running median window testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_running_median_sorted_window_core;
    import rmsw_pkg::*;

    localparam int IDLE_PCT = 38;
    localparam int RANDOM_ITEMS = 850;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;
    int        fail_count;
    int        medians_owed;
    int        beats_sent = 0;
    logic      calm = 1'b0;

    running_median_sorted_window_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    median_window_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .medians_owed (medians_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_running_median_sorted_window_core: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic in_beat_t make_beat(input logic act, input logic [15:0] moist,
                                           input logic [15:0] temp);
        in_beat_t b;
        b.action = act;
        b.sample_moisture = moist;
        b.sample_temperature = temp;
        return b;
    endfunction

    function automatic logic [15:0] pick_moisture();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return INVALID_MOISTURE;
        if (roll < 12)
            return 16'h0000;
        if (roll < 17)
            return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
        if (roll < 60)
            return 16'($urandom_range(60)) - 16'd30;
        if (roll < 80)
            return 16'($urandom_range(4000)) - 16'd2000;
        return 16'($urandom);
    endfunction

    task automatic send_beat(input in_beat_t b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        calm <= (beats_sent >= 400 && beats_sent < 560);
    endtask

    initial
    begin
        int total_beats;
        int seg_len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero moisture into the empty window lands on the middle and takes the equal path.
        send_beat(make_beat(ACTION_SAMPLE, 16'd0, 16'd123));
        send_beat(make_beat(ACTION_SAMPLE, 16'd100, 16'd7));
        send_beat(make_beat(ACTION_SAMPLE, -16'sd50, -16'sd7));
        send_beat(make_beat(ACTION_SAMPLE, 16'h7fff, 16'h8000));
        send_beat(make_beat(ACTION_SAMPLE, 16'h8000, 16'h7fff));
        send_beat(make_beat(ACTION_SAMPLE, INVALID_MOISTURE, 16'd555));
        send_beat(make_beat(ACTION_SAMPLE, -16'sd9998, 16'd1));
        send_beat(make_beat(ACTION_SAMPLE, -16'sd10000, 16'd2));
        send_beat(make_beat(ACTION_SAMPLE, 16'd0, 16'hffff));
        send_beat(make_beat(ACTION_SAMPLE, 16'd500, 16'd10));
        send_beat(make_beat(ACTION_SAMPLE, 16'd500, 16'd11));
        send_beat(make_beat(ACTION_SAMPLE, 16'd500, 16'd12));
        send_beat(make_beat(ACTION_SAMPLE, 16'd1, 16'd0));
        send_beat(make_beat(ACTION_SAMPLE, 16'hffff, 16'd0));
        send_beat(make_beat(ACTION_CLEAR, 16'h7fff, 16'h8000));
        send_beat(make_beat(ACTION_CLEAR, 16'h8000, 16'h7fff));
        send_beat(make_beat(ACTION_SAMPLE, 16'd250, 16'd20));
        send_beat(make_beat(ACTION_SAMPLE, 16'h5555, 16'haaaa));
        send_beat(make_beat(ACTION_SAMPLE, 16'haaaa, 16'h5555));
        send_beat(make_beat(ACTION_SAMPLE, INVALID_MOISTURE, 16'h0000));

        // The first run is long enough to fill the count and then send samples past the full count.
        total_beats = beats_sent + RANDOM_ITEMS;
        seg_len = 290;
        while (beats_sent < total_beats)
        begin
            send_beat(make_beat(ACTION_CLEAR, 16'($urandom), 16'($urandom)));
            for (int k = 0; k < seg_len && beats_sent < total_beats; k++)
            begin
                send_beat(make_beat(ACTION_SAMPLE, pick_moisture(), 16'($urandom)));
            end
            seg_len = ($urandom_range(7) == 0) ? 270 : $urandom_range(120, 4);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (medians_owed != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("tb_running_median_sorted_window_core: done, clean");
        else
            $display("tb_running_median_sorted_window_core: done, errors");
        $finish;
    end

endmodule
